FILE: rtl/palette_upscale_320_to_800_top_macros.svh
// assertion macros for the palette upscaler
`ifndef PALETTE_UPSCALE_320_TO_800_TOP_MACROS_SVH
`define PALETTE_UPSCALE_320_TO_800_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define PU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pu_pkg.sv
// shared types and constants of the palette upscaler
`default_nettype none

package pu_pkg;

  // default frame and palette sizes
  localparam int SRC_WIDTH_DEF       = 320;
  localparam int SRC_HEIGHT_DEF      = 240;
  localparam int PALETTE_ENTRIES_DEF = 256;

  // field widths
  localparam int INDEX_W = 8;
  localparam int COMP_W  = 8;
  localparam int COLOR_W = 3 * COMP_W;
  localparam int OUT_X_W = 10;
  localparam int OUT_Y_W = 9;
  localparam int BEAT_W  = 3;

  // operation codes
  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  // final write of a pixel in an even or an odd source column
  localparam logic [BEAT_W-1:0] LAST_BEAT_EVEN = 3'd3;
  localparam logic [BEAT_W-1:0] LAST_BEAT_ODD  = 3'd5;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] color_index;
    logic [COMP_W-1:0]  component0;
    logic [COMP_W-1:0]  component1;
    logic [COMP_W-1:0]  component2;
  } in_item_t;

  typedef struct packed {
    logic [COMP_W-1:0]  byte0;
    logic [COMP_W-1:0]  byte1;
    logic [COMP_W-1:0]  byte2;
    logic [OUT_X_W-1:0] out_x;
    logic [OUT_Y_W-1:0] out_y;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/pu_in_if.sv
// input and result channels of the palette upscaler
`default_nettype none

interface pu_in_if import pu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pu_out_if import pu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/palette_upscale_320_to_800_top.sv
// palette lookup and 2.5x by 2x nearest-neighbour upscaler, top level
`default_nettype none

`include "palette_upscale_320_to_800_top_macros.svh"

// Takes palette writes and 8-bit indexed pixels in raster order and issues
// 24-bit colour writes for the upscaled frame, one write per cycle on out_ch
// while out_ch.ready is high. A palette write gives no result. A pixel gives
// four writes in an even source column and six in an odd one, so a column
// pair gives ten writes. The first write of a pixel passes through the
// palette read register and then the write sequencer register before it
// reaches out_ch. A pixel in the read register waits while the sequencer is
// busy, so the next pixel is taken while the current one is still being
// written. Reading a palette entry that was never written gives an undefined
// colour; an index at or above PALETTE_ENTRIES gives black and writes there
// are dropped.
module palette_upscale_320_to_800_top
  import pu_pkg::*;
#(
  parameter int SRC_WIDTH       = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT      = SRC_HEIGHT_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pu_in_if.sink     in_ch,
  pu_out_if.source  out_ch
);

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam int COL_W  = $clog2(SRC_WIDTH);
  localparam int ROW_W  = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  // palette store
  logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];

  // raster position
  logic [COL_W-1:0]   src_col_r, src_col_nxt;
  logic [ROW_W-1:0]   src_row_r, src_row_nxt;
  logic [OUT_X_W-1:0] x_base_r, x_base_nxt;

  // read stage
  logic               rd_valid_r, rd_valid_nxt;
  logic [COLOR_W-1:0] rd_color_r;
  logic               rd_oob_r;
  logic [OUT_X_W-1:0] rd_x_r;
  logic [OUT_Y_W-1:0] rd_y_r;
  logic               rd_odd_r;

  // write sequencer
  logic               seq_valid_r, seq_valid_nxt;
  logic [BEAT_W-1:0]  beat_r, beat_nxt;
  logic [COLOR_W-1:0] seq_color_r;
  logic [OUT_X_W-1:0] seq_x_r;
  logic [OUT_Y_W-1:0] seq_y_r;
  logic               seq_odd_r;

  logic               in_fire, out_fire;
  logic               pix_take, pal_we, idx_in_range;
  logic               seq_done, seq_load;
  logic [BEAT_W-1:0]  last_beat;
  logic [OUT_X_W-1:0] x_off;
  logic               y_off;

  // transfers and handshake
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign idx_in_range = {1'b0, in_ch.data.color_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);
  assign pix_take     = in_fire && (in_ch.data.op == OP_PIXEL);
  assign pal_we       = in_fire && (in_ch.data.op == OP_PAL_WRITE) && idx_in_range;

  assign last_beat = seq_odd_r ? LAST_BEAT_ODD : LAST_BEAT_EVEN;
  assign seq_done  = out_fire && (beat_r == last_beat);
  assign seq_load  = rd_valid_r && (!seq_valid_r || seq_done);

  assign in_ch.ready = !rd_valid_r || seq_load;

  // palette write and registered read
  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[in_ch.data.color_index[ADDR_W-1:0]] <=
        {in_ch.data.component2, in_ch.data.component1, in_ch.data.component0};
    end
    if (pix_take) begin
      rd_color_r <= palette_mem[in_ch.data.color_index[ADDR_W-1:0]];
    end
  end

  // raster position advance
  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    x_base_nxt  = x_base_r;
    if (pix_take) begin
      x_base_nxt  = x_base_r + (src_col_r[0] ? OUT_X_W'(3) : OUT_X_W'(2));
      src_col_nxt = src_col_r + COL_W'(1);
      if (src_col_r == COL_W'(SRC_WIDTH - 1)) begin
        src_col_nxt = '0;
        x_base_nxt  = '0;
        src_row_nxt = src_row_r + ROW_W'(1);
        if (src_row_r == ROW_W'(SRC_HEIGHT - 1)) begin
          src_row_nxt = '0;
        end
      end
    end
  end

  // read stage and sequencer occupancy
  always_comb begin
    rd_valid_nxt  = pix_take || (rd_valid_r && !seq_load);
    seq_valid_nxt = seq_valid_r;
    beat_nxt      = beat_r;
    if (seq_load) begin
      seq_valid_nxt = 1'b1;
      beat_nxt      = '0;
    end else if (seq_done) begin
      seq_valid_nxt = 1'b0;
    end else if (out_fire) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      x_base_r    <= '0;
      rd_valid_r  <= 1'b0;
      seq_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      x_base_r    <= x_base_nxt;
      rd_valid_r  <= rd_valid_nxt;
      seq_valid_r <= seq_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (pix_take) begin
      rd_oob_r <= !idx_in_range;
      rd_x_r   <= x_base_r;
      rd_y_r   <= OUT_Y_W'(src_row_r) << 1;
      rd_odd_r <= src_col_r[0];
    end
  end

  // sequencer payload, black for an index beyond the palette
  always_ff @(posedge clk) begin
    if (seq_load) begin
      seq_color_r <= rd_oob_r ? '0 : rd_color_r;
      seq_x_r     <= rd_x_r;
      seq_y_r     <= rd_y_r;
      seq_odd_r   <= rd_odd_r;
    end
  end

  // offsets of each write within the output block
  always_comb begin
    case (beat_r)
      3'd0:    begin x_off = OUT_X_W'(0); y_off = 1'b0; end
      3'd1:    begin x_off = OUT_X_W'(1); y_off = 1'b0; end
      3'd2:    begin x_off = OUT_X_W'(0); y_off = 1'b1; end
      3'd3:    begin x_off = OUT_X_W'(1); y_off = 1'b1; end
      3'd4:    begin x_off = OUT_X_W'(2); y_off = 1'b0; end
      3'd5:    begin x_off = OUT_X_W'(2); y_off = 1'b1; end
      default: begin x_off = OUT_X_W'(0); y_off = 1'b0; end
    endcase
  end

  // result channel
  assign out_ch.valid      = seq_valid_r;
  assign out_ch.data.byte0 = seq_color_r[3*COMP_W-1:2*COMP_W];
  assign out_ch.data.byte1 = seq_color_r[2*COMP_W-1:COMP_W];
  assign out_ch.data.byte2 = seq_color_r[COMP_W-1:0];
  assign out_ch.data.out_x = seq_x_r + x_off;
  assign out_ch.data.out_y = seq_y_r + OUT_Y_W'(y_off);
  assign out_ch.data.last  = (beat_r == last_beat);

  // checks
  `PU_ASSERT_NOW(a_beat_bound, seq_valid_r, beat_r <= last_beat, "write sequencer beyond final write")
  `PU_ASSERT_NEXT(a_beat_step, out_fire && !seq_done, seq_valid_r && (beat_r == $past(beat_r) + BEAT_W'(1)), "write sequencer did not advance by one")
  `PU_ASSERT_NOW(a_stall_cause, !in_ch.ready, rd_valid_r && seq_valid_r, "input stalled with a free stage")

endmodule

`default_nettype wire

FILE: sim/palette_upscale_320_to_800_top_tb.sv
// self-checking testbench for the palette upscaler top level
`default_nettype none

module palette_upscale_320_to_800_top_tb;
  import pu_pkg::*;

  localparam int     HALF_PERIOD  = 4;
  localparam int     RESET_CYCLES = 8;
  localparam int     RANDOM_ITEMS = 24;
  localparam int     PAUSE_AT     = 12;
  localparam int     TAIL_ITEMS   = 6;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     MAX_PRINTED  = 40;
  localparam longint CYCLE_LIMIT  = 2_000_000;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_LONG_HOLD} rx_mode_t;

  // one row of the directed stimulus, with the writes typed in where obvious
  typedef struct {
    logic       op;
    logic [7:0] idx;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    bit         typed;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [9:0] x;
    logic [8:0] y;
    bit         odd;
  } dir_row_t;

  localparam int DIR_N = 21;

  dir_row_t dir_rows [DIR_N] = '{
    '{OP_PAL_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PAL_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PAL_WRITE, 8'h80, 8'h12, 8'h34, 8'h56, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PAL_WRITE, 8'h01, 8'haa, 8'h55, 8'hf0, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'hff, 8'h00, 8'h00, 8'h00, 1, 8'hff, 8'hff, 8'hff, 10'd2,  9'd0, 1},
    '{OP_PIXEL,     8'h80, 8'h00, 8'h00, 8'h00, 1, 8'h56, 8'h34, 8'h12, 10'd5,  9'd0, 0},
    '{OP_PIXEL,     8'h01, 8'h00, 8'h00, 8'h00, 1, 8'hf0, 8'h55, 8'haa, 10'd7,  9'd0, 1},
    '{OP_PAL_WRITE, 8'hff, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'hff, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 10'd10, 9'd0, 0},
    '{OP_PAL_WRITE, 8'h80, 8'h0f, 8'h00, 8'hf0, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h80, 8'h00, 8'h00, 8'h00, 1, 8'hf0, 8'h00, 8'h0f, 10'd12, 9'd0, 1},
    '{OP_PAL_WRITE, 8'h7f, 8'h01, 8'h02, 8'h03, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PAL_WRITE, 8'hfe, 8'h80, 8'h40, 8'h20, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h7f, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'hfe, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h00, 8'hff, 8'hff, 8'hff, 1, 8'h00, 8'h00, 8'h00, 10'd20, 9'd0, 0},
    '{OP_PAL_WRITE, 8'h55, 8'haa, 8'h55, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h55, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PAL_WRITE, 8'h00, 8'hff, 8'hff, 8'hff, 0, 8'h00, 8'h00, 8'h00, 10'd0,  9'd0, 0},
    '{OP_PIXEL,     8'h00, 8'h5a, 8'h5a, 8'h5a, 1, 8'hff, 8'hff, 8'hff, 10'd25, 9'd0, 0}
  };

  logic clk;
  logic rst_n;

  pu_in_if  in_ch ();
  pu_out_if out_ch ();

  palette_upscale_320_to_800_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: palette copy and raster position of the next pixel
  logic [23:0] lut_rgb [256];
  bit          is_written [256];
  logic [7:0]  written_idx [$];
  logic [8:0]  raster_col = '0;
  logic [7:0]  raster_row = '0;
  logic [9:0]  x_base = '0;

  out_item_t pending_writes [$];
  int        mismatches = 0;

  // sender and receiver pacing
  bit       tx_gaps_on = 1'b1;
  bit       rx_stalls_on = 1'b1;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_tick = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // mismatch report: one line, counted, printing capped
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    end
  endtask

  // current output position of the next pixel, then move the raster on
  function automatic void step_raster(output logic [9:0] x, output logic [8:0] y,
                                      output bit odd);
    x   = x_base;
    y   = {raster_row, 1'b0};
    odd = raster_col[0];
    x_base = x_base + (odd ? 10'd3 : 10'd2);
    raster_col = raster_col + 9'd1;
    if (raster_col >= SRC_WIDTH_DEF) begin
      raster_col = '0;
      x_base     = '0;
      raster_row = raster_row + 8'd1;
      if (raster_row >= SRC_HEIGHT_DEF) begin
        raster_row = '0;
      end
    end
  endfunction

  // the 2x2 block, plus the third column for an odd source column
  function automatic void queue_block(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                      logic [9:0] x, logic [8:0] y, bit odd);
    out_item_t w;
    int        n;
    n = odd ? 6 : 4;
    for (int k = 0; k < n; k++) begin
      w.byte0 = b0;
      w.byte1 = b1;
      w.byte2 = b2;
      w.out_x = x + ((k < 4) ? 10'(k % 2) : 10'd2);
      w.out_y = y + ((k < 4) ? 9'(k / 2) : 9'(k - 4));
      w.last  = (k == n - 1);
      pending_writes.push_back(w);
    end
  endfunction

  // palette write updates the copy; pixel queues its colour writes
  function automatic void predict_item(in_item_t it);
    logic [9:0] x;
    logic [8:0] y;
    bit         odd;
    if (it.op == OP_PAL_WRITE) begin
      lut_rgb[it.color_index] = {it.component2, it.component1, it.component0};
      if (!is_written[it.color_index]) begin
        is_written[it.color_index] = 1'b1;
        written_idx.push_back(it.color_index);
      end
    end else begin
      step_raster(x, y, odd);
      queue_block(lut_rgb[it.color_index][23:16], lut_rgb[it.color_index][15:8],
                  lut_rgb[it.color_index][7:0], x, y, odd);
    end
  endfunction

  // random item; pixels only use palette entries already written
  function automatic in_item_t random_item(int write_pct);
    in_item_t it;
    it.op = ($urandom_range(0, 99) < write_pct) ? OP_PAL_WRITE : OP_PIXEL;
    if (it.op == OP_PAL_WRITE) begin
      it.color_index = 8'($urandom_range(0, 255));
    end else begin
      it.color_index = written_idx[$urandom_range(0, written_idx.size() - 1)];
    end
    it.component0 = 8'($urandom);
    it.component1 = 8'($urandom);
    it.component2 = 8'($urandom);
    return it;
  endfunction

  // present one item and hold it until the transfer
  task automatic offer_item(in_item_t it);
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // move to the next falling edge, inserting a gap at the end of a burst
  task automatic pace_sender();
    @(negedge clk);
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the input idle until every predicted write has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_writes.size() != 0);
  endtask

  // receiver stall pattern, changed every so often
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 101 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    if (!rx_stalls_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:      out_ch.ready <= 1'b1;
        RX_COIN:      out_ch.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC:  out_ch.ready <= (rx_tick % 5) < 3;
        RX_LONG_HOLD: out_ch.ready <= (rx_tick % 16) >= 10;
        default:      out_ch.ready <= 1'b1;
      endcase
    end
  end

  // result checking against the oldest pending write
  always @(posedge clk) begin : check_writes
    out_item_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_writes.size() == 0) begin
        flag_mismatch("write with nothing pending, out_x", 32'(out_ch.data.out_x), '0);
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.data.byte0 !== want.byte0) begin
          flag_mismatch("byte0", 32'(out_ch.data.byte0), 32'(want.byte0));
        end
        if (out_ch.data.byte1 !== want.byte1) begin
          flag_mismatch("byte1", 32'(out_ch.data.byte1), 32'(want.byte1));
        end
        if (out_ch.data.byte2 !== want.byte2) begin
          flag_mismatch("byte2", 32'(out_ch.data.byte2), 32'(want.byte2));
        end
        if (out_ch.data.out_x !== want.out_x) begin
          flag_mismatch("out_x", 32'(out_ch.data.out_x), 32'(want.out_x));
        end
        if (out_ch.data.out_y !== want.out_y) begin
          flag_mismatch("out_y", 32'(out_ch.data.out_y), 32'(want.out_y));
        end
        if (out_ch.data.last !== want.last) begin
          flag_mismatch("last", 32'(out_ch.data.last), 32'(want.last));
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout with %0d writes still pending", pending_writes.size());
    $display("palette_upscale_320_to_800_top_tb: FAIL");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    in_item_t   it;
    logic [9:0] x;
    logic [8:0] y;
    bit         odd;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows: extremes, overwrite then read, ignored components
    for (int r = 0; r < DIR_N; r++) begin
      it = '{dir_rows[r].op, dir_rows[r].idx, dir_rows[r].c0, dir_rows[r].c1,
             dir_rows[r].c2};
      offer_item(it);
      if (dir_rows[r].typed) begin
        step_raster(x, y, odd);
        queue_block(dir_rows[r].b0, dir_rows[r].b1, dir_rows[r].b2,
                    dir_rows[r].x, dir_rows[r].y, dir_rows[r].odd);
      end else begin
        predict_item(it);
      end
      pace_sender();
    end

    // random mix of palette writes and pixels, with one full drain midway
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        wait_drained();
      end
      it = random_item(25);
      offer_item(it);
      predict_item(it);
      pace_sender();
    end

    // pixels without idling until the raster wraps at the end of the row
    wait_drained();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    do begin
      it = random_item(0);
      offer_item(it);
      predict_item(it);
      pace_sender();
    end while (raster_col != 0);

    // first pixels of the next row, idling again
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      it = random_item(25);
      offer_item(it);
      predict_item(it);
      pace_sender();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("palette_upscale_320_to_800_top_tb: PASS");
    end else begin
      $display("palette_upscale_320_to_800_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
